[src/tvsg_pkg.sv]
// ----------------------------------------------------------------------------
// tvsg_pkg: torus vertex generator shared types and helpers
// Types, register codes and arithmetic helpers for the vertex pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tvsg_pkg;

	localparam int CNT_W        = 11;
	localparam int TEX_W        = 16;
	localparam int IDX_W        = 21;
	localparam int MAX_SEGMENTS = 1024;
	localparam int CORDIC_STEPS = 28;
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

	typedef enum logic [2:0] {
		REG_MAJOR, REG_TUBE, REG_SIDES, REG_RINGS,
		REG_OFFX, REG_OFFY, REG_OFFZ, REG_RING_FIRST
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] vnum;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] second;
		logic             strip_valid;
		logic [TEX_W-1:0] tu;
		logic [TEX_W-1:0] tv;
	} meta_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0]         quad;
	} cor_t;

	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} trig_t;

	// arctangent in 2^-32 turn
	function automatic logic signed [31:0] atan_turn(input logic [4:0] k);
		logic signed [31:0] r;
		unique case (k)
			5'd0:  r = 32'sd536870912;
			5'd1:  r = 32'sd316933406;
			5'd2:  r = 32'sd167458907;
			5'd3:  r = 32'sd85004756;
			5'd4:  r = 32'sd42667331;
			5'd5:  r = 32'sd21354465;
			5'd6:  r = 32'sd10680862;
			5'd7:  r = 32'sd5340245;
			5'd8:  r = 32'sd2670163;
			5'd9:  r = 32'sd1335087;
			5'd10: r = 32'sd667544;
			5'd11: r = 32'sd333772;
			5'd12: r = 32'sd166886;
			5'd13: r = 32'sd83443;
			5'd14: r = 32'sd41722;
			5'd15: r = 32'sd20861;
			5'd16: r = 32'sd10430;
			5'd17: r = 32'sd5215;
			5'd18: r = 32'sd2608;
			5'd19: r = 32'sd1304;
			5'd20: r = 32'sd652;
			5'd21: r = 32'sd326;
			5'd22: r = 32'sd163;
			5'd23: r = 32'sd81;
			5'd24: r = 32'sd41;
			5'd25: r = 32'sd20;
			5'd26: r = 32'sd10;
			5'd27: r = 32'sd5;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// one restoring division step; dividend bits below are zero
	function automatic logic [CNT_W:0] div_bit(input logic [CNT_W-1:0] r,
	                                           input logic [CNT_W-1:0] d);
		logic [CNT_W:0] t;
		t = {r, 1'b0};
		if (t >= {1'b0, d})
			return {1'b1, CNT_W'(t - {1'b0, d})};
		return {1'b0, t[CNT_W-1:0]};
	endfunction

	function automatic cor_t cor_step(input cor_t c, input logic [4:0] k);
		cor_t n;
		logic signed [31:0] xs, ys;
		xs = c.x >>> k;
		ys = c.y >>> k;
		n = c;
		if (!c.z[31]) begin
			n.x = c.x - ys;
			n.y = c.y + xs;
			n.z = c.z - atan_turn(k);
		end else begin
			n.x = c.x + ys;
			n.y = c.y - xs;
			n.z = c.z + atan_turn(k);
		end
		return n;
	endfunction

	function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
		if (v > ONE_Q30)
			return ONE_Q30;
		if (v < -ONE_Q30)
			return -ONE_Q30;
		return v;
	endfunction

	function automatic trig_t quad_map(input cor_t c);
		trig_t t;
		unique case (c.quad)
			2'd0: begin t.c = c.x;  t.s = c.y;  end
			2'd1: begin t.c = -c.y; t.s = c.x;  end
			2'd2: begin t.c = -c.x; t.s = -c.y; end
			2'd3: begin t.c = c.y;  t.s = -c.x; end
		endcase
		t.c = clamp_q30(t.c);
		t.s = clamp_q30(t.s);
		return t;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sh007FFFFFFF)
			return 32'h7FFFFFFF;
		if (v < -40'sh0080000000)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		if (c == '0)
			return CNT_W'(1);
		if ({1'b0, c} > (CNT_W+1)'(MAX_SEGMENTS))
			return CNT_W'(MAX_SEGMENTS);
		return c;
	endfunction

endpackage
`default_nettype wire

[src/torus_vertex_and_strip_generator_unit.sv]
// ----------------------------------------------------------------------------
// torus_vertex_and_strip_generator_unit: parametric torus vertex pipeline
// Position, normal, texture coordinates and strip indices of one grid vertex.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; every stage advances together unless the
//   output register holds a result that is stalled.
// Length is set by the bit-per-stage angle/texture dividers and the 28 CORDIC
//   stages, followed by quadrant map, two multiply stages and two sum stages.
// Reset: clears valid bits and loads register defaults; no clearing pass.
`default_nettype none
module torus_vertex_and_strip_generator_unit
	import tvsg_pkg::*;
#(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// config port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [4:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic      [31:0]            prdata,
	output logic                        pready,
	// input items
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [CNT_W-1:0]       ring_index,
	input  wire logic [CNT_W-1:0]       side_index,
	// result items
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [31:0]          pos_x,
	output logic signed [31:0]          pos_y,
	output logic signed [31:0]          pos_z,
	output logic signed [15:0]          norm_x,
	output logic signed [15:0]          norm_y,
	output logic signed [15:0]          norm_z,
	output logic [TEX_W-1:0]            tex_u,
	output logic [TEX_W-1:0]            tex_v,
	output logic [IDX_W-1:0]            vertex_number,
	output logic [IDX_W-1:0]            strip_first,
	output logic [IDX_W-1:0]            strip_second,
	output logic                        strip_valid
);

	localparam int DIVS = (ANGLE_BITS > TEX_W) ? ANGLE_BITS : TEX_W;

	typedef struct packed {
		logic [CNT_W-1:0]      th_r;
		logic [CNT_W-1:0]      ph_r;
		logic [CNT_W-1:0]      tu_r;
		logic [CNT_W-1:0]      tv_r;
		logic [ANGLE_BITS-1:0] th_q;
		logic [ANGLE_BITS-1:0] ph_q;
		logic [TEX_W-1:0]      tu_q;
		logic [TEX_W-1:0]      tv_q;
		logic [CNT_W-1:0]      rings;
		logic [CNT_W-1:0]      sides;
		logic [CNT_W-1:0]      rings_p1;
		logic [CNT_W-1:0]      sides_p1;
	} div_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [30:0]        major_q, tube_q;
	logic [CNT_W-1:0]   sides_q, rings_q;
	logic signed [31:0] offx_q, offy_q, offz_q;
	logic               ring_first_q;
	reg_idx_t           reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q      <= 31'd65536;
			tube_q       <= 31'd32768;
			sides_q      <= CNT_W'(16);
			rings_q      <= CNT_W'(16);
			offx_q       <= '0;
			offy_q       <= '0;
			offz_q       <= '0;
			ring_first_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_MAJOR:      major_q      <= pwdata[30:0];
				REG_TUBE:       tube_q       <= pwdata[30:0];
				REG_SIDES:      sides_q      <= pwdata[CNT_W-1:0];
				REG_RINGS:      rings_q      <= pwdata[CNT_W-1:0];
				REG_OFFX:       offx_q       <= pwdata;
				REG_OFFY:       offy_q       <= pwdata;
				REG_OFFZ:       offz_q       <= pwdata;
				REG_RING_FIRST: ring_first_q <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAJOR:      prdata = {1'b0, major_q};
			REG_TUBE:       prdata = {1'b0, tube_q};
			REG_SIDES:      prdata = 32'(sides_q);
			REG_RINGS:      prdata = 32'(rings_q);
			REG_OFFX:       prdata = offx_q;
			REG_OFFY:       prdata = offy_q;
			REG_OFFZ:       prdata = offz_q;
			REG_RING_FIRST: prdata = 32'(ring_first_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Global advance: the whole pipe moves unless the output is held
	// ------------------------------------------------------------------
	logic en;
	logic vld_s8;
	assign en       = !vld_s8 || !out_stall;
	assign in_stall = !en;

	// ------------------------------------------------------------------
	// Stage 1: clamp counts and indices, strip indices, divider setup
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] rings_c, sides_c, i_c, j_c, per_ring;
	logic [IDX_W:0]   vnum_w, b_w;
	div_t             div_in;
	meta_t            meta_in;

	always_comb begin
		rings_c  = eff_count(rings_q);
		sides_c  = eff_count(sides_q);
		i_c      = (ring_index > rings_c) ? rings_c : ring_index;
		j_c      = (side_index > sides_c) ? sides_c : side_index;
		per_ring = sides_c + CNT_W'(1);
		vnum_w   = (IDX_W+1)'(i_c) * (IDX_W+1)'(per_ring) + (IDX_W+1)'(j_c);
		b_w      = vnum_w + (IDX_W+1)'(per_ring);

		meta_in.vnum        = vnum_w[IDX_W-1:0];
		meta_in.strip_valid = (i_c < rings_c);
		meta_in.tu          = '0;
		meta_in.tv          = '0;
		if (i_c < rings_c) begin
			meta_in.first  = ring_first_q ? vnum_w[IDX_W-1:0] : b_w[IDX_W-1:0];
			meta_in.second = ring_first_q ? b_w[IDX_W-1:0] : vnum_w[IDX_W-1:0];
		end else begin
			// last ring has no strip
			meta_in.first  = '0;
			meta_in.second = '0;
		end

		// integer part of idx/count is 1 only for the full turn, which wraps
		div_in.th_r     = (i_c == rings_c) ? '0 : i_c;
		div_in.ph_r     = (j_c == sides_c) ? '0 : j_c;
		div_in.tu_r     = j_c;
		div_in.tv_r     = i_c;
		div_in.th_q     = '0;
		div_in.ph_q     = '0;
		div_in.tu_q     = '0;
		div_in.tv_q     = '0;
		div_in.rings    = rings_c;
		div_in.sides    = sides_c;
		div_in.rings_p1 = rings_c + CNT_W'(1);
		div_in.sides_p1 = per_ring;
	end

	// ------------------------------------------------------------------
	// Divider stages: one quotient bit per stage for all four quotients
	// ------------------------------------------------------------------
	div_t  div_s  [0:DIVS];
	meta_t mdiv_s [0:DIVS];
	logic  vdiv_s [0:DIVS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vdiv_s[0] <= 1'b0;
		else if (en)
			vdiv_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0]  <= div_in;
			mdiv_s[0] <= meta_in;
		end
	end

	for (genvar k = 0; k < DIVS; k++) begin : g_div
		div_t             nd;
		logic [CNT_W:0]   th_b, ph_b, tu_b, tv_b;

		always_comb begin
			th_b = div_bit(div_s[k].th_r, div_s[k].rings);
			ph_b = div_bit(div_s[k].ph_r, div_s[k].sides);
			tu_b = div_bit(div_s[k].tu_r, div_s[k].sides_p1);
			tv_b = div_bit(div_s[k].tv_r, div_s[k].rings_p1);
			nd   = div_s[k];
			if (k < ANGLE_BITS) begin
				nd.th_r = th_b[CNT_W-1:0];
				nd.th_q = {div_s[k].th_q[ANGLE_BITS-2:0], th_b[CNT_W]};
				nd.ph_r = ph_b[CNT_W-1:0];
				nd.ph_q = {div_s[k].ph_q[ANGLE_BITS-2:0], ph_b[CNT_W]};
			end
			if (k < TEX_W) begin
				nd.tu_r = tu_b[CNT_W-1:0];
				nd.tu_q = {div_s[k].tu_q[TEX_W-2:0], tu_b[CNT_W]};
				nd.tv_r = tv_b[CNT_W-1:0];
				nd.tv_q = {div_s[k].tv_q[TEX_W-2:0], tv_b[CNT_W]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vdiv_s[k+1] <= 1'b0;
			else if (en)
				vdiv_s[k+1] <= vdiv_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1]  <= nd;
				mdiv_s[k+1] <= mdiv_s[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC stages: theta and phi lanes, one rotation per stage
	// ------------------------------------------------------------------
	cor_t  th_s  [1:CORDIC_STEPS];
	cor_t  ph_s  [1:CORDIC_STEPS];
	meta_t mcor_s[1:CORDIC_STEPS];
	logic  vcor_s[1:CORDIC_STEPS];

	cor_t        th_init, ph_init;
	meta_t       meta_cor;
	logic [31:0] th_a32, ph_a32;

	always_comb begin
		// angle as a 32-bit turn fraction; top two bits pick the quadrant
		th_a32       = 32'(div_s[DIVS].th_q) << (32 - ANGLE_BITS);
		ph_a32       = 32'(div_s[DIVS].ph_q) << (32 - ANGLE_BITS);
		th_init.x    = CORDIC_GAIN_Q30;
		th_init.y    = '0;
		th_init.z    = $signed({2'b00, th_a32[29:0]});
		th_init.quad = th_a32[31:30];
		ph_init.x    = CORDIC_GAIN_Q30;
		ph_init.y    = '0;
		ph_init.z    = $signed({2'b00, ph_a32[29:0]});
		ph_init.quad = ph_a32[31:30];
		meta_cor     = mdiv_s[DIVS];
		meta_cor.tu  = div_s[DIVS].tu_q;
		meta_cor.tv  = div_s[DIVS].tv_q;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
		cor_t  th_src, ph_src;
		meta_t m_src;
		logic  v_src;

		if (k == 0) begin : g_first
			assign th_src = th_init;
			assign ph_src = ph_init;
			assign m_src  = meta_cor;
			assign v_src  = vdiv_s[DIVS];
		end else begin : g_next
			assign th_src = th_s[k];
			assign ph_src = ph_s[k];
			assign m_src  = mcor_s[k];
			assign v_src  = vcor_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vcor_s[k+1] <= 1'b0;
			else if (en)
				vcor_s[k+1] <= v_src;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				th_s[k+1]   <= cor_step(th_src, 5'(k));
				ph_s[k+1]   <= cor_step(ph_src, 5'(k));
				mcor_s[k+1] <= m_src;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: quadrant map and clamp to [-1, 1] in Q1.30
	// Stage 5: products with cos(phi), tube*cos(phi), tube*sin(phi)
	// Stage 6: d, normals, z position
	// Stage 7: cos/sin(theta) times d
	// Stage 8: x, y positions; output register
	// ------------------------------------------------------------------
	trig_t th_t4_s4, ph_t4_s4;
	meta_t m_s4, m_s5, m_s6, m_s7, m_s8;
	logic  vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [63:0] tcp_s5, ctcp_s5, stcp_s5, tsp_s5;
	logic signed [31:0] ct_s5, st_s5, sp_s5;

	logic signed [34:0] d_s6;
	logic signed [31:0] ct_s6, st_s6;
	logic signed [15:0] nx_s6, ny_s6, nz_s6;
	logic [31:0]        pz_s6;

	logic signed [66:0] ctd_s7, std_s7;
	logic signed [15:0] nx_s7, ny_s7, nz_s7;
	logic [31:0]        pz_s7;

	logic [31:0]        px_s8, py_s8, pz_s8;
	logic signed [15:0] nx_s8, ny_s8, nz_s8;

	logic signed [31:0] tube_sg, major_sg;
	assign tube_sg  = $signed({1'b0, tube_q});
	assign major_sg = $signed({1'b0, major_q});

	// stage 6 arithmetic
	logic signed [63:0] tcp_r, ctcp_r, stcp_r, tsp_r;
	logic signed [31:0] sp_r;
	logic signed [17:0] nx_w, ny_w;
	logic signed [39:0] pz_w;

	always_comb begin
		tcp_r  = tcp_s5 + 64'sd536870912;                   // + 2^29
		ctcp_r = ctcp_s5 + 64'sd35184372088832;             // + 2^45
		stcp_r = stcp_s5 + 64'sd35184372088832;
		tsp_r  = tsp_s5 + 64'sd536870912;
		sp_r   = sp_s5 + 32'sd32768;                        // + 2^15
		nx_w   = $signed(ctcp_r[63:46]);
		ny_w   = -$signed(stcp_r[63:46]);
		pz_w   = 40'(offz_q) + 40'($signed(tsp_r[63:30]));
	end

	// stage 8 arithmetic
	logic signed [66:0] ctd_r, std_r;
	logic signed [39:0] px_w, py_w;

	always_comb begin
		ctd_r = ctd_s7 + 67'sd536870912;
		std_r = std_s7 + 67'sd536870912;
		px_w  = 40'(offx_q) + 40'($signed(ctd_r[66:30]));
		py_w  = 40'(offy_q) - 40'($signed(std_r[66:30]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vcor_s[CORDIC_STEPS];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_t4_s4 <= quad_map(th_s[CORDIC_STEPS]);
			ph_t4_s4 <= quad_map(ph_s[CORDIC_STEPS]);
			m_s4     <= mcor_s[CORDIC_STEPS];

			tcp_s5  <= tube_sg * ph_t4_s4.c;
			ctcp_s5 <= th_t4_s4.c * ph_t4_s4.c;
			stcp_s5 <= th_t4_s4.s * ph_t4_s4.c;
			tsp_s5  <= tube_sg * ph_t4_s4.s;
			ct_s5   <= th_t4_s4.c;
			st_s5   <= th_t4_s4.s;
			sp_s5   <= ph_t4_s4.s;
			m_s5    <= m_s4;

			d_s6  <= 35'(major_sg) + 35'($signed(tcp_r[63:30]));
			ct_s6 <= ct_s5;
			st_s6 <= st_s5;
			nx_s6 <= nx_w[15:0];
			ny_s6 <= ny_w[15:0];
			nz_s6 <= sp_r[31:16];
			pz_s6 <= sat32(pz_w);
			m_s6  <= m_s5;

			ctd_s7 <= 67'(ct_s6) * 67'(d_s6);
			std_s7 <= 67'(st_s6) * 67'(d_s6);
			nx_s7  <= nx_s6;
			ny_s7  <= ny_s6;
			nz_s7  <= nz_s6;
			pz_s7  <= pz_s6;
			m_s7   <= m_s6;

			px_s8 <= sat32(px_w);
			py_s8 <= sat32(py_w);
			pz_s8 <= pz_s7;
			nx_s8 <= nx_s7;
			ny_s8 <= ny_s7;
			nz_s8 <= nz_s7;
			m_s8  <= m_s7;
		end
	end

	assign out_valid     = vld_s8;
	assign pos_x         = px_s8;
	assign pos_y         = py_s8;
	assign pos_z         = pz_s8;
	assign norm_x        = nx_s8;
	assign norm_y        = ny_s8;
	assign norm_z        = nz_s8;
	assign tex_u         = m_s8.tu;
	assign tex_v         = m_s8.tv;
	assign vertex_number = m_s8.vnum;
	assign strip_first   = m_s8.first;
	assign strip_second  = m_s8.second;
	assign strip_valid   = m_s8.strip_valid;

`ifndef NO_ASSERTIONS
	a_no_strip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !strip_valid) |-> (strip_first == '0 && strip_second == '0))
		else $error("strip indices not zero on last ring");

	a_strip_has_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && strip_valid) |->
		(strip_first == vertex_number || strip_second == vertex_number))
		else $error("strip pair does not contain the vertex");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (norm_x <= 16'sd16384 && norm_x >= -16'sd16384 &&
		               norm_y <= 16'sd16384 && norm_y >= -16'sd16384 &&
		               norm_z <= 16'sd16384 && norm_z >= -16'sd16384))
		else $error("normal component out of unit range");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(vertex_number) &&
		                              $stable(pos_x)))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

[tb/torus_vertex_and_strip_generator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// torus_vertex_and_strip_generator_unit_tb: self-checking vertex generator test
// Writes the geometry registers, streams grid vertices with random gaps and
// output stalls, and compares every result item with a bit-exact predictor or typed-in values.
// ----------------------------------------------------------------------------
`default_nettype none
module torus_vertex_and_strip_generator_unit_tb;
	import tvsg_pkg::*;

	localparam int LATENCY   = 50;
	localparam int MAX_CYCLE = 400000;

	typedef struct {
		logic [31:0] px, py, pz;
		logic [15:0] nx, ny, nz;
		logic [15:0] tu, tv;
		logic [20:0] vnum, first, second;
		logic        sv;
		bit          typed; // directed row with a typed-in value
	} vertex_t;

	typedef struct {
		logic [10:0] ring, side;
		bit          typed;
		logic [31:0] px, py, pz;
		logic [15:0] nx, ny, nz;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [10:0] ring_index = '0, side_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic signed [15:0] norm_x, norm_y, norm_z;
	logic [15:0] tex_u, tex_v;
	logic [20:0] vertex_number, strip_first, strip_second;
	logic strip_valid;

	torus_vertex_and_strip_generator_unit uut (.*);

	always #5 clk = ~clk;

	// shadow copy of the geometry registers
	logic [30:0] major_r = 31'd65536, tube_r = 31'd32768;
	logic [10:0] sides_r = 11'd16, rings_r = 11'd16;
	logic signed [31:0] offx_r = 0, offy_r = 0, offz_r = 0;
	logic ring_first_r = 1'b0;

	vertex_t expected_vertices[$];
	int errors = 0, cycles = 0, sent = 0, seen = 0;
	bit calm = 1'b0;    // no gaps or stalls during this stretch

	// angle idx/count of a turn -> (cos, sin) in Q1.30 via 28 CORDIC rotations
	task automatic turn_sincos(input int unsigned idx, input int unsigned cnt,
	                           output longint c, output longint s);
		longint unsigned a;
		logic [31:0] a32;
		longint x, y, z, rc, rs;
		longint atan_k[28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5};
		a = ((longint'(idx)) << 16) / cnt;
		a32 = {a[15:0], 16'h0};
		z = a32[29:0];
		x = 652032874;
		y = 0;
		for (int k = 0; k < 28; k++) begin
			longint xs, ys;
			xs = x >>> k;
			ys = y >>> k;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_k[k];
			end else begin
				x += ys; y -= xs; z += atan_k[k];
			end
		end
		case (a32[31:30])
			2'd0: begin rc = x; rs = y; end
			2'd1: begin rc = -y; rs = x; end
			2'd2: begin rc = -x; rs = -y; end
			default: begin rc = y; rs = -x; end
		endcase
		c = rc > 1073741824 ? 1073741824 : (rc < -1073741824 ? -1073741824 : rc);
		s = rs > 1073741824 ? 1073741824 : (rs < -1073741824 ? -1073741824 : rs);
	endtask

	function automatic longint rnd_shift(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic int unsigned used_count(input logic [10:0] c);
		if (c == 0)
			return 1;
		return c > 1024 ? 1024 : c;
	endfunction

	task automatic predict_vertex(input logic [10:0] ri, input logic [10:0] si,
	                              output vertex_t v);
		int unsigned rings, sides, i, j;
		longint ct, st, cp, sp, d, tube, per;
		longint unsigned a, b;
		rings = used_count(rings_r);
		sides = used_count(sides_r);
		i = ri > rings ? rings : ri;
		j = si > sides ? sides : si;
		turn_sincos(i, rings, ct, st);
		turn_sincos(j, sides, cp, sp);
		tube = tube_r;
		d = longint'(major_r) + rnd_shift(tube * cp, 30);
		v.px = clip32(longint'(offx_r) + rnd_shift(ct * d, 30));
		v.py = clip32(longint'(offy_r) - rnd_shift(st * d, 30));
		v.pz = clip32(longint'(offz_r) + rnd_shift(tube * sp, 30));
		v.nx = 16'(rnd_shift(ct * cp, 46));
		v.ny = 16'(-rnd_shift(st * cp, 46));
		v.nz = 16'(rnd_shift(sp, 16));
		per = sides + 1;
		v.tu = 16'((longint'(j) << 16) / per);
		v.tv = 16'((longint'(i) << 16) / (rings + 1));
		a = i * per + j;
		b = (i + 1) * per + j;
		v.vnum = a[20:0];
		v.sv = i < rings;
		v.first = !v.sv ? '0 : (ring_first_r ? a[20:0] : b[20:0]);
		v.second = !v.sv ? '0 : (ring_first_r ? b[20:0] : a[20:0]);
		v.typed = 1'b0;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		errors++;
		if (errors <= 40)
			$display("MISMATCH item %0d %s: got %0h, expected %0h", seen, what, got, exp);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(r) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (r)
			REG_MAJOR: major_r = val[30:0];
			REG_TUBE: tube_r = val[30:0];
			REG_SIDES: sides_r = val[10:0];
			REG_RINGS: rings_r = val[10:0];
			REG_OFFX: offx_r = val;
			REG_OFFY: offy_r = val;
			REG_OFFZ: offz_r = val;
			REG_RING_FIRST: ring_first_r = val[0];
			default: ;
		endcase
	endtask

	// one vertex; expectation queued at the accepting edge. in_valid stays
	// high between back-to-back items and drops only in a gap or a drain.
	task automatic send_vertex(input row_t r);
		vertex_t v;
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		predict_vertex(r.ring, r.side, v);
		if (r.typed) begin
			v.px = r.px; v.py = r.py; v.pz = r.pz;
			v.nx = r.nx; v.ny = r.ny; v.nz = r.nz;
			v.typed = 1'b1;
		end
		in_valid <= 1'b1;
		ring_index <= r.ring;
		side_index <= r.side;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_vertices.push_back(v);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_vertices.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	task automatic random_vertices(input int n);
		row_t r;
		int unsigned lim;
		for (int k = 0; k < n; k++) begin
			r.typed = 1'b0;
			lim = used_count(rings_r);
			r.ring = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(lim));
			lim = used_count(sides_r);
			r.side = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(lim));
			send_vertex(r);
		end
	endtask

	// output stall and the checker
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 26);

	always @(posedge clk) begin
		vertex_t e;
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLE) begin
			$display("torus_vertex_and_strip_generator_unit test failed");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				report_mismatch("unexpected item", vertex_number, 0);
			end else begin
				e = expected_vertices.pop_front();
				if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
				if (pos_z !== e.pz) report_mismatch("pos_z", pos_z, e.pz);
				if (norm_x !== e.nx) report_mismatch("norm_x", norm_x, e.nx);
				if (norm_y !== e.ny) report_mismatch("norm_y", norm_y, e.ny);
				if (norm_z !== e.nz) report_mismatch("norm_z", norm_z, e.nz);
				if (tex_u !== e.tu) report_mismatch("tex_u", tex_u, e.tu);
				if (tex_v !== e.tv) report_mismatch("tex_v", tex_v, e.tv);
				if (vertex_number !== e.vnum)
					report_mismatch("vertex_number", vertex_number, e.vnum);
				if (strip_first !== e.first)
					report_mismatch("strip_first", strip_first, e.first);
				if (strip_second !== e.second)
					report_mismatch("strip_second", strip_second, e.second);
				if (strip_valid !== e.sv) report_mismatch("strip_valid", strip_valid, e.sv);
			end
			seen++;
		end
	end

	// Directed rows. Typed rows: after reset, angle 0 and the seam of a full
	// turn (index == count wraps to zero) give cos = 1 exactly, so the
	// position is (major + tube, 0, 0) and the normal (1, 0, 0) in Q2.14.
	row_t dir_rows[$] = '{
		'{11'd0, 11'd0, 1'b1, 32'd98304, 32'd0, 32'd0, 16'd16384, 16'd0, 16'd0},
		'{11'd16, 11'd16, 1'b1, 32'd98304, 32'd0, 32'd0, 16'd16384, 16'd0, 16'd0},
		'{11'd2047, 11'd2047, 1'b1, 32'd98304, 32'd0, 32'd0, 16'd16384, 16'd0, 16'd0},
		'{11'd4, 11'd0, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd8, 11'd4, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd12, 11'd8, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd15, 11'd12, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd0, 11'd15, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd1024, 11'd1, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd17, 11'd1024, 1'b0, '0, '0, '0, '0, '0, '0},
		'{11'd3, 11'd7, 1'b0, '0, '0, '0, '0, '0, '0}
	};

	initial begin
		row_t r;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults
		calm = 1'b1;
		foreach (dir_rows[k])
			send_vertex(dir_rows[k]);
		calm = 1'b0;
		drain();

		// extremes: big radii and offsets saturate, zero and oversized counts
		write_reg(REG_MAJOR, 32'h7FFFFFFF);
		write_reg(REG_TUBE, 32'h7FFFFFFF);
		write_reg(REG_OFFX, 32'h7FFFFFFF);
		write_reg(REG_OFFY, 32'h80000000);
		write_reg(REG_OFFZ, 32'h7FFFFFFF);
		write_reg(REG_SIDES, 32'd0);
		write_reg(REG_RINGS, 32'd2047);
		write_reg(REG_RING_FIRST, 32'd1);
		for (int k = 0; k < 8; k++) begin
			r = '{11'($urandom_range(2047)), 11'($urandom_range(2)), 1'b0,
				'0, '0, '0, '0, '0, '0};
			send_vertex(r);
		end
		r = '{11'd1024, 11'd1, 1'b0, '0, '0, '0, '0, '0, '0};
		send_vertex(r);
		r = '{11'd1023, 11'd0, 1'b0, '0, '0, '0, '0, '0, '0};
		send_vertex(r);
		drain();

		write_reg(REG_MAJOR, 32'd0);
		write_reg(REG_TUBE, 32'd0);
		write_reg(REG_OFFX, 32'h80000000);
		write_reg(REG_OFFY, 32'h7FFFFFFF);
		write_reg(REG_OFFZ, 32'h80000000);
		write_reg(REG_SIDES, 32'd1024);
		write_reg(REG_RINGS, 32'd1);
		write_reg(REG_RING_FIRST, 32'd0);
		random_vertices(40);
		drain();

		// random settings, random vertices; one calm stretch
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_MAJOR, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h400000));
			write_reg(REG_TUBE, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h200000));
			write_reg(REG_SIDES, $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 40));
			write_reg(REG_RINGS, $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 40));
			write_reg(REG_OFFX, $urandom_range(1) ? $urandom : $urandom_range(32'h100000));
			write_reg(REG_OFFY, $urandom);
			write_reg(REG_OFFZ, $urandom_range(1) ? $urandom : -$urandom_range(32'h100000));
			write_reg(REG_RING_FIRST, $urandom);
			calm = (ph == 3);
			random_vertices(25);
			drain();   // sender holds off until every result is in
			random_vertices(20);
			calm = 1'b0;
			drain();
		end

		$display("Covered %0d vertices over reset, extreme and random geometry settings,", sent);
		$display("with random input gaps and output stalls; %0d results checked.", seen);
		if (errors == 0)
			$display("torus_vertex_and_strip_generator_unit test passed");
		else
			$display("torus_vertex_and_strip_generator_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
